/* rtl/lvn_pkg.sv */
`timescale 1ns / 1ps
package lvn_pkg;

    // Bit layout of one automaton floor: position i sits at bit WORD_W-1-i.
    localparam int WORD_W = 64;

    localparam int MAX_FLOORS_DEF    = 8;
    localparam int STACK_DEPTH_DEF   = 64;
    localparam int ALPHABET_SIZE_DEF = 256;
    localparam int MAX_PATTERN_DEF   = 63;

    localparam logic ACT_LOAD = 1'b0;
    localparam logic ACT_WALK = 1'b1;

    localparam logic ST_OK  = 1'b0;
    localparam logic ST_ERR = 1'b1;

    typedef enum logic {
        S_IDLE,
        S_EXEC
    } t_state;

    typedef struct packed {
        logic              action;
        logic [7:0]        symbol;
        logic              pattern_end;
        logic signed [3:0] distance_limit;
        logic [5:0]        stack_level;
    } t_in_word;

    typedef struct packed {
        logic capture;
        logic exec_fire;
    } t_cmd;

    typedef struct packed {
        logic out_free;
    } t_stat;

endpackage

/* rtl/lvn_in_if.sv */
`timescale 1ns / 1ps
interface lvn_in_if;
    logic              valid;
    logic              ready;
    logic              action;
    logic [7:0]        symbol;
    logic              pattern_end;
    logic signed [3:0] distance_limit;
    logic [5:0]        stack_level;

    modport source (
        output valid, action, symbol, pattern_end, distance_limit, stack_level,
        input  ready
    );
    modport sink (
        input  valid, action, symbol, pattern_end, distance_limit, stack_level,
        output ready
    );
endinterface

/* rtl/lvn_out_if.sv */
`timescale 1ns / 1ps
interface lvn_out_if;
    logic valid;
    logic ready;
    logic any_active;
    logic status;

    modport source (
        output valid, any_active, status,
        input  ready
    );
    modport sink (
        input  valid, any_active, status,
        output ready
    );
endinterface

/* rtl/lvn_ram.sv */
`timescale 1ns / 1ps
module lvn_ram #(
    parameter int WIDTH = 64,
    parameter int DEPTH = 64
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;
endmodule

/* rtl/lvn_ctrl.sv */
`timescale 1ns / 1ps
module lvn_ctrl (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_in_valid,
    output logic          o_in_ready,
    input  lvn_pkg::t_stat i_stat,
    output lvn_pkg::t_cmd  o_cmd
);
    import lvn_pkg::*;

    t_state r_state;
    t_state n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    n_state = S_EXEC;
                end
            end
            S_EXEC: begin
                if (i_stat.out_free) begin
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_comb begin
        o_in_ready      = 1'b0;
        o_cmd.capture   = 1'b0;
        o_cmd.exec_fire = 1'b0;
        case (r_state)
            S_IDLE: begin
                o_in_ready    = 1'b1;
                o_cmd.capture = i_in_valid;
            end
            S_EXEC: begin
                // The word is only finished once the output register can take it.
                o_cmd.exec_fire = i_stat.out_free;
            end
            default: begin
                o_in_ready = 1'b0;
            end
        endcase
    end
endmodule

/* rtl/lvn_datapath.sv */
`timescale 1ns / 1ps
module lvn_datapath #(
    parameter int MAX_FLOORS    = 8,
    parameter int STACK_DEPTH   = 64,
    parameter int ALPHABET_SIZE = 256,
    parameter int MAX_PATTERN   = 63
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  lvn_pkg::t_in_word i_word,
    input  lvn_pkg::t_cmd     i_cmd,
    output lvn_pkg::t_stat    o_stat,
    input  logic              i_out_ready,
    output logic              o_out_valid,
    output logic              o_out_any,
    output logic              o_out_status
);
    import lvn_pkg::*;

    localparam int AAW   = $clog2(ALPHABET_SIZE);
    localparam int LW    = $clog2(STACK_DEPTH);
    localparam int FLW   = (MAX_FLOORS > 1) ? $clog2(MAX_FLOORS) : 1;
    localparam int ROW_W = MAX_FLOORS * WORD_W;
    localparam logic [WORD_W-1:0] TOP_BIT = {1'b1, {(WORD_W-1){1'b0}}};

    t_in_word               r_word;
    logic                   r_open;
    logic                   r_ovf;
    logic [5:0]             r_len;
    logic [FLW-1:0]         r_limit;
    logic [WORD_W-1:0]      r_pos_mask;
    logic                   r_seeded;
    logic [ALPHABET_SIZE-1:0] r_mask_vld;
    logic [STACK_DEPTH-1:0] r_row_vld;
    logic                   r_out_valid;
    logic                   r_out_any;
    logic                   r_out_status;

    logic                   sym_ok;
    logic [AAW-1:0]         sym_idx;
    logic [6:0]             lvl1;
    logic                   lvl_ok;
    logic [LW-1:0]          src_idx;
    logic [LW-1:0]          dst_idx;
    logic                   len_ok;
    logic [5:0]             n_len;
    logic                   n_ovf;
    logic [6:0]             lim_raw;
    logic [FLW-1:0]         n_limit;
    logic [WORD_W-1:0]      n_pos_mask;
    logic                   n_out_any;
    logic                   n_out_status;
    logic                   is_load;
    logic                   is_walk;

    logic [AAW-1:0]         mask_raddr;
    logic [WORD_W-1:0]      mask_rdata;
    logic [WORD_W-1:0]      mask_old;
    logic [WORD_W-1:0]      sym_mask;
    logic [WORD_W-1:0]      mask_wdata;
    logic                   mask_we;

    logic [LW-1:0]          row_raddr;
    logic [ROW_W-1:0]       row_rdata;
    logic [ROW_W-1:0]       seed_row;
    logic [ROW_W-1:0]       src_row;
    logic [ROW_W-1:0]       dst_row;
    logic                   row_we;
    logic [WORD_W-1:0]      s_fl [MAX_FLOORS];
    logic [WORD_W-1:0]      d_fl [MAX_FLOORS];
    logic [WORD_W-1:0]      acc;

    // Read addresses come straight from the port while a word is taken, so the
    // memory data is ready in the execute cycle.
    assign mask_raddr = i_cmd.capture ? i_word.symbol[AAW-1:0] : r_word.symbol[AAW-1:0];
    assign row_raddr  = i_cmd.capture ? LW'(i_word.stack_level) : LW'(r_word.stack_level);

    lvn_ram #(.WIDTH(WORD_W), .DEPTH(ALPHABET_SIZE)) u_mask_ram (
        .i_clk   (i_clk),
        .i_we    (mask_we),
        .i_waddr (sym_idx),
        .i_wdata (mask_wdata),
        .i_raddr (mask_raddr),
        .o_rdata (mask_rdata)
    );

    lvn_ram #(.WIDTH(ROW_W), .DEPTH(STACK_DEPTH)) u_row_ram (
        .i_clk   (i_clk),
        .i_we    (row_we),
        .i_waddr (dst_idx),
        .i_wdata (dst_row),
        .i_raddr (row_raddr),
        .o_rdata (row_rdata)
    );

    assign is_load = (r_word.action == ACT_LOAD);
    assign is_walk = (r_word.action == ACT_WALK);

    assign sym_ok  = ({1'b0, r_word.symbol} < 9'(ALPHABET_SIZE));
    assign sym_idx = r_word.symbol[AAW-1:0];
    assign lvl1    = {1'b0, r_word.stack_level} + 7'd1;
    assign lvl_ok  = ({2'b00, lvl1} < 9'(STACK_DEPTH));
    assign src_idx = LW'(r_word.stack_level);
    assign dst_idx = LW'(lvl1);

    // Pattern load: one new position per symbol until the pattern is full.
    assign len_ok     = (r_len < 6'(MAX_PATTERN));
    assign n_len      = len_ok ? (r_len + 6'd1) : r_len;
    assign n_ovf      = r_ovf | ~len_ok;
    assign mask_old   = r_mask_vld[sym_idx] ? mask_rdata : '0;
    assign sym_mask   = sym_ok ? mask_old : '0;
    assign mask_wdata = mask_old | (TOP_BIT >> r_len);
    assign mask_we    = i_cmd.exec_fire & is_load & len_ok & sym_ok;

    // A negative distance limit takes the pattern length instead.
    assign lim_raw    = r_word.distance_limit[3] ? {1'b0, n_len}
                                                 : {4'b0000, r_word.distance_limit[2:0]};
    assign n_limit    = (lim_raw > 7'(MAX_FLOORS - 1)) ? FLW'(MAX_FLOORS - 1) : FLW'(lim_raw);
    assign n_pos_mask = {WORD_W{1'b1}} << (6'(WORD_W - 1) - n_len);

    always_comb begin
        for (int f = 0; f < MAX_FLOORS; f++) begin
            seed_row[f*WORD_W +: WORD_W] = (FLW'(f) <= r_limit) ? (TOP_BIT >> f) : '0;
        end
    end

    // Level 0 is never written by a walk; after set-up it reads as the seed.
    always_comb begin
        if (r_row_vld[src_idx]) begin
            src_row = row_rdata;
        end else if (r_word.stack_level == 6'd0 && r_seeded) begin
            src_row = seed_row;
        end else begin
            src_row = '0;
        end
    end

    always_comb begin
        for (int f = 0; f < MAX_FLOORS; f++) begin
            s_fl[f] = src_row[f*WORD_W +: WORD_W];
        end
        d_fl[0] = (s_fl[0] & sym_mask) >> 1;
        acc     = d_fl[0];
        for (int f = 1; f < MAX_FLOORS; f++) begin
            if (FLW'(f) <= r_limit) begin
                d_fl[f] = (((s_fl[f] & sym_mask) >> 1) | s_fl[f-1] | (s_fl[f-1] >> 1)
                          | (d_fl[f-1] >> 1)) & r_pos_mask;
                acc     = acc | d_fl[f];
            end else begin
                d_fl[f] = '0;
            end
        end
        for (int f = 0; f < MAX_FLOORS; f++) begin
            dst_row[f*WORD_W +: WORD_W] = d_fl[f];
        end
    end

    assign row_we = i_cmd.exec_fire & is_walk & lvl_ok;

    always_comb begin
        if (is_load) begin
            n_out_any    = 1'b0;
            n_out_status = n_ovf ? ST_ERR : ST_OK;
        end else if (lvl_ok) begin
            n_out_any    = (acc != '0);
            n_out_status = ST_OK;
        end else begin
            n_out_any    = 1'b0;
            n_out_status = ST_ERR;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.capture) begin
            r_word <= i_word;
        end
        if (i_cmd.exec_fire) begin
            r_out_any    <= n_out_any;
            r_out_status <= n_out_status;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_open      <= 1'b0;
            r_ovf       <= 1'b0;
            r_len       <= '0;
            r_limit     <= '0;
            r_pos_mask  <= '0;
            r_seeded    <= 1'b0;
            r_mask_vld  <= '0;
            r_row_vld   <= '0;
            r_out_valid <= 1'b0;
        end else begin
            // The first load word of a pattern wipes the symbol masks.
            if (i_cmd.capture && i_word.action == ACT_LOAD && !r_open) begin
                r_mask_vld <= '0;
                r_len      <= '0;
                r_ovf      <= 1'b0;
                r_open     <= 1'b1;
            end
            if (i_cmd.exec_fire && is_load) begin
                r_len <= n_len;
                r_ovf <= n_ovf;
                if (mask_we) begin
                    r_mask_vld[sym_idx] <= 1'b1;
                end
                if (r_word.pattern_end) begin
                    r_limit    <= n_limit;
                    r_pos_mask <= n_pos_mask;
                    r_row_vld  <= '0;
                    r_seeded   <= 1'b1;
                    r_open     <= 1'b0;
                end
            end
            if (row_we) begin
                r_row_vld[dst_idx] <= 1'b1;
            end
            if (i_cmd.exec_fire) begin
                r_out_valid <= 1'b1;
            end else if (r_out_valid && i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    assign o_stat.out_free = ~r_out_valid | i_out_ready;
    assign o_out_valid     = r_out_valid;
    assign o_out_any       = r_out_any;
    assign o_out_status    = r_out_status;

`ifndef SYNTHESIS
    a_fire_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.exec_fire |=> r_out_valid)
        else $error("finished word did not reach the output register");

    a_any_ok: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid |-> !(r_out_any && r_out_status))
        else $error("active states reported together with an error status");

    a_len_max: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_len <= 6'(MAX_PATTERN))
        else $error("pattern length beyond the maximum");

    a_load_quiet: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_cmd.exec_fire && is_load) |=> !r_out_any)
        else $error("load word reported active states");

    a_no_overlap: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(i_cmd.capture && i_cmd.exec_fire))
        else $error("new word taken while one is still executing");
`endif
endmodule

/* rtl/levenshtein_nfa_bit_parallel_step.sv */
`timescale 1ns / 1ps
// Bit-parallel Levenshtein automaton with a stack of levels.
// Input channel i_in carries one word per item: action 0 loads the next
// pattern symbol (pattern_end marks the last one, whose distance_limit sets
// the floor limit), action 1 walks one text symbol from stack_level to
// stack_level + 1. Output channel o_out returns one word per input word:
// any_active for walks, and status (1 for a dropped pattern symbol or a
// level out of range).
// Each word is accepted in the idle state, which starts the reads of the
// symbol-mask memory and the level memory; the execute state then combines
// the floors and writes back. The result is valid in the cycle after that,
// and the next word is taken only after the last one has executed.
// One result waits in the output register; a stalled receiver holds the
// next word in its execute cycle until that register frees.
// Reset clears the control state, the pattern and the floor limit; masks
// and levels read as zero until written, with no clearing pass.
module levenshtein_nfa_bit_parallel_step #(
    parameter int MAX_FLOORS    = lvn_pkg::MAX_FLOORS_DEF,
    parameter int STACK_DEPTH   = lvn_pkg::STACK_DEPTH_DEF,
    parameter int ALPHABET_SIZE = lvn_pkg::ALPHABET_SIZE_DEF,
    parameter int MAX_PATTERN   = lvn_pkg::MAX_PATTERN_DEF
) (
    input  logic      i_clk,
    input  logic      i_rst_n,
    lvn_in_if.sink    i_in,
    lvn_out_if.source o_out
);
    import lvn_pkg::*;

    t_in_word in_word;
    t_cmd     cmd;
    t_stat    stat;

    assign in_word.action         = i_in.action;
    assign in_word.symbol         = i_in.symbol;
    assign in_word.pattern_end    = i_in.pattern_end;
    assign in_word.distance_limit = i_in.distance_limit;
    assign in_word.stack_level    = i_in.stack_level;

    lvn_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in.valid),
        .o_in_ready (i_in.ready),
        .i_stat     (stat),
        .o_cmd      (cmd)
    );

    lvn_datapath #(
        .MAX_FLOORS    (MAX_FLOORS),
        .STACK_DEPTH   (STACK_DEPTH),
        .ALPHABET_SIZE (ALPHABET_SIZE),
        .MAX_PATTERN   (MAX_PATTERN)
    ) u_datapath (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_word       (in_word),
        .i_cmd        (cmd),
        .o_stat       (stat),
        .i_out_ready  (o_out.ready),
        .o_out_valid  (o_out.valid),
        .o_out_any    (o_out.any_active),
        .o_out_status (o_out.status)
    );
endmodule

/* bench/tb_top.sv */
`timescale 1ns / 1ps
module tb_top;
    import lvn_pkg::*;

    localparam int NUM_FLOORS   = MAX_FLOORS_DEF;
    localparam int NUM_LEVELS   = STACK_DEPTH_DEF;
    localparam int NUM_SYMBOLS  = ALPHABET_SIZE_DEF;
    localparam int PATTERN_MAX  = MAX_PATTERN_DEF;
    localparam logic [WORD_W-1:0] FIRST_POS = {1'b1, {(WORD_W-1){1'b0}}};

    localparam int ITEM_TARGET  = 400;
    localparam int PHASE_ITEMS  = 135;
    localparam int HOLD_AT      = 300;
    localparam int HOLD_CYCLES  = 60;
    localparam int DRAIN_CYCLES = 8;
    localparam int RUN_LIMIT    = 200000;
    localparam int DIR_N        = 23;

    typedef struct packed {
        logic any_active;
        logic status;
    } t_answer;

    typedef struct packed {
        t_in_word w;
        logic     typed;
        t_answer  ans;
    } t_row;

    logic i_clk;
    logic i_rst_n;

    lvn_in_if  in_ch ();
    lvn_out_if out_ch ();

    levenshtein_nfa_bit_parallel_step dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (in_ch),
        .o_out   (out_ch)
    );

    // Automaton state as the block should hold it.
    logic [WORD_W-1:0] sym_mask [NUM_SYMBOLS];
    logic [WORD_W-1:0] floors [NUM_LEVELS][NUM_FLOORS];
    int                pat_len;
    int                floor_lim;
    logic [WORD_W-1:0] pos_mask;
    bit                pat_open;
    bit                pat_ovf;

    t_answer pending_answers [$];

    int sent_cnt;
    int err_cnt;
    int cycle_cnt;
    int snd_idle_pct;
    int rcv_idle_pct;

    // Rows with a typed answer are checked against it; the rest use the predictor.
    t_row dir_rows [DIR_N] = '{
        '{'{ACT_WALK, 8'd0,   1'b0, 4'sd0,  6'd0 }, 1'b1, '{1'b0, ST_OK }},
        '{'{ACT_WALK, 8'd255, 1'b0, 4'sd0,  6'd62}, 1'b1, '{1'b0, ST_OK }},
        '{'{ACT_WALK, 8'd0,   1'b0, 4'sd0,  6'd63}, 1'b1, '{1'b0, ST_ERR}},
        '{'{ACT_LOAD, 8'd97,  1'b0, 4'sd0,  6'd0 }, 1'b1, '{1'b0, ST_OK }},
        '{'{ACT_LOAD, 8'd0,   1'b0, 4'sd0,  6'd0 }, 1'b1, '{1'b0, ST_OK }},
        '{'{ACT_LOAD, 8'd255, 1'b1, -4'sd1, 6'd0 }, 1'b1, '{1'b0, ST_OK }},
        '{'{ACT_WALK, 8'd97,  1'b0, 4'sd0,  6'd0 }, 1'b0, '{1'b0, ST_OK }},
        '{'{ACT_WALK, 8'd0,   1'b0, 4'sd0,  6'd1 }, 1'b0, '{1'b0, ST_OK }},
        '{'{ACT_WALK, 8'd255, 1'b0, 4'sd0,  6'd2 }, 1'b0, '{1'b0, ST_OK }},
        '{'{ACT_WALK, 8'd1,   1'b0, 4'sd0,  6'd3 }, 1'b0, '{1'b0, ST_OK }},
        '{'{ACT_WALK, 8'd98,  1'b0, 4'sd0,  6'd1 }, 1'b0, '{1'b0, ST_OK }},
        '{'{ACT_WALK, 8'd255, 1'b1, 4'sd7,  6'd63}, 1'b1, '{1'b0, ST_ERR}},
        '{'{ACT_LOAD, 8'd10,  1'b1, 4'sd0,  6'd0 }, 1'b1, '{1'b0, ST_OK }},
        '{'{ACT_WALK, 8'd10,  1'b0, 4'sd0,  6'd0 }, 1'b0, '{1'b0, ST_OK }},
        '{'{ACT_WALK, 8'd11,  1'b0, 4'sd0,  6'd0 }, 1'b0, '{1'b0, ST_OK }},
        '{'{ACT_LOAD, 8'd1,   1'b0, 4'sd0,  6'd0 }, 1'b1, '{1'b0, ST_OK }},
        '{'{ACT_WALK, 8'd1,   1'b0, 4'sd0,  6'd0 }, 1'b0, '{1'b0, ST_OK }},
        '{'{ACT_LOAD, 8'd2,   1'b1, 4'sd7,  6'd0 }, 1'b1, '{1'b0, ST_OK }},
        '{'{ACT_WALK, 8'd3,   1'b0, 4'sd0,  6'd0 }, 1'b0, '{1'b0, ST_OK }},
        '{'{ACT_WALK, 8'd3,   1'b0, 4'sd0,  6'd1 }, 1'b0, '{1'b0, ST_OK }},
        '{'{ACT_WALK, 8'd2,   1'b0, 4'sd0,  6'd2 }, 1'b0, '{1'b0, ST_OK }},
        '{'{ACT_LOAD, 8'd200, 1'b1, 4'sb1000, 6'd0 }, 1'b1, '{1'b0, ST_OK }},
        '{'{ACT_WALK, 8'd200, 1'b0, 4'sd0,  6'd62}, 1'b0, '{1'b0, ST_OK }}
    };

    function automatic t_answer step_automaton(input t_in_word w);
        t_answer           r;
        logic [WORD_W-1:0] m;
        logic [WORD_W-1:0] acc;
        logic [WORD_W-1:0] v;
        logic [WORD_W-1:0] nxt [NUM_FLOORS];
        int                lvl;
        r = '{1'b0, ST_OK};
        if (w.action == ACT_LOAD) begin
            // The first load after set-up starts a new pattern.
            if (!pat_open) begin
                foreach (sym_mask[i]) sym_mask[i] = '0;
                pat_len  = 0;
                pat_ovf  = 1'b0;
                pat_open = 1'b1;
            end
            if (pat_len < PATTERN_MAX) begin
                sym_mask[w.symbol] |= FIRST_POS >> pat_len;
                pat_len++;
            end else begin
                pat_ovf = 1'b1;
            end
            r.status = pat_ovf ? ST_ERR : ST_OK;
            if (w.pattern_end) begin
                floor_lim = w.distance_limit[3] ? pat_len : int'(w.distance_limit[2:0]);
                if (floor_lim > NUM_FLOORS - 1) floor_lim = NUM_FLOORS - 1;
                pos_mask = {WORD_W{1'b1}} << (WORD_W - 1 - pat_len);
                foreach (floors[i, j]) floors[i][j] = '0;
                for (int f = 0; f <= floor_lim; f++) floors[0][f] = FIRST_POS >> f;
                pat_open = 1'b0;
            end
        end else if (int'(w.stack_level) + 1 >= NUM_LEVELS) begin
            r.status = ST_ERR;
        end else begin
            lvl    = int'(w.stack_level);
            m      = sym_mask[w.symbol];
            nxt[0] = (floors[lvl][0] & m) >> 1;
            acc    = nxt[0];
            for (int f = 1; f < NUM_FLOORS; f++) begin
                if (f <= floor_lim) begin
                    v = ((floors[lvl][f] & m) >> 1) | floors[lvl][f-1] |
                        (floors[lvl][f-1] >> 1) | (nxt[f-1] >> 1);
                    nxt[f] = v & pos_mask;
                    acc |= nxt[f];
                end else begin
                    nxt[f] = '0;
                end
            end
            for (int f = 0; f < NUM_FLOORS; f++) floors[lvl+1][f] = nxt[f];
            r.any_active = (acc != '0);
        end
        return r;
    endfunction

    task automatic report_mismatch(input string what, input int got, input int want);
        $display("mismatch at cycle %0d: %s got %0d want %0d", cycle_cnt, what, got, want);
        err_cnt++;
    endtask

    task automatic send_word(input t_in_word w, input logic typed, input t_answer typed_ans,
                             output t_answer ans);
        if (sent_cnt < PHASE_ITEMS) begin
            snd_idle_pct = 32;
            rcv_idle_pct = 58;
        end else if (sent_cnt < 2 * PHASE_ITEMS) begin
            snd_idle_pct = 58;
            rcv_idle_pct = 32;
        end else begin
            snd_idle_pct = 0;
            rcv_idle_pct = 0;
        end
        while ($urandom_range(0, 99) < snd_idle_pct) begin
            in_ch.valid <= 1'b0;
            @(posedge i_clk);
        end
        in_ch.valid          <= 1'b1;
        in_ch.action         <= w.action;
        in_ch.symbol         <= w.symbol;
        in_ch.pattern_end    <= w.pattern_end;
        in_ch.distance_limit <= w.distance_limit;
        in_ch.stack_level    <= w.stack_level;
        do @(posedge i_clk); while (!in_ch.ready);
        ans = step_automaton(w);
        pending_answers.push_back(typed ? typed_ans : ans);
        sent_cnt++;
    endtask

    initial begin
        i_clk = 1'b0;
        forever #2 i_clk = ~i_clk;
    end

    initial begin
        while (cycle_cnt < RUN_LIMIT) begin
            @(posedge i_clk);
            cycle_cnt++;
        end
        $display("CHECKS FAILED");
        $finish;
    end

    // Result side: check each accepted word, then pick ready for the next cycle.
    initial begin
        int      hold_left;
        bit      held;
        t_answer want;
        hold_left = 0;
        held      = 1'b0;
        out_ch.ready <= 1'b0;
        forever begin
            @(posedge i_clk);
            if (i_rst_n && out_ch.valid && out_ch.ready) begin
                if (pending_answers.size() == 0) begin
                    report_mismatch("unexpected word, status", int'(out_ch.status), -1);
                end else begin
                    want = pending_answers.pop_front();
                    if (out_ch.any_active !== want.any_active)
                        report_mismatch("any_active", int'(out_ch.any_active),
                                        int'(want.any_active));
                    if (out_ch.status !== want.status)
                        report_mismatch("status", int'(out_ch.status), int'(want.status));
                end
            end
            // One long stall while the sender keeps offering, to back up the block.
            if (!held && sent_cnt >= HOLD_AT) begin
                held      = 1'b1;
                hold_left = HOLD_CYCLES;
            end
            if (hold_left > 0) begin
                hold_left--;
                out_ch.ready <= 1'b0;
            end else begin
                out_ch.ready <= ($urandom_range(0, 99) >= rcv_idle_pct);
            end
        end
    end

    initial begin
        t_answer    ans;
        t_in_word   w;
        int         plen;
        int         depth;
        int         nwalk;
        int         pat_no;
        logic [7:0] base;
        i_rst_n              <= 1'b0;
        in_ch.valid          <= 1'b0;
        in_ch.action         <= ACT_LOAD;
        in_ch.symbol         <= '0;
        in_ch.pattern_end    <= 1'b0;
        in_ch.distance_limit <= '0;
        in_ch.stack_level    <= '0;
        foreach (sym_mask[i]) sym_mask[i] = '0;
        foreach (floors[i, j]) floors[i][j] = '0;
        pat_len      = 0;
        floor_lim    = 0;
        pos_mask     = '0;
        pat_open     = 1'b0;
        pat_ovf      = 1'b0;
        sent_cnt     = 0;
        err_cnt      = 0;
        snd_idle_pct = 32;
        rcv_idle_pct = 58;
        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;

        foreach (dir_rows[i]) send_word(dir_rows[i].w, dir_rows[i].typed, dir_rows[i].ans, ans);

        // Random patterns over a small alphabet, each followed by a trie-style walk
        // that goes deeper while states stay alive and backs up when they die, at depth 61 or at random.
        pat_no = 0;
        while (sent_cnt < ITEM_TARGET) begin
            if (pat_no == 0)
                plen = 66;
            else if ($urandom_range(0, 19) == 0)
                plen = $urandom_range(60, 70);
            else if ($urandom_range(0, 3) == 0)
                plen = $urandom_range(8, 12);
            else
                plen = $urandom_range(1, 7);
            base = 8'($urandom_range(0, 255));
            for (int k = 0; k < plen; k++) begin
                w.action         = ACT_LOAD;
                w.symbol         = base + 8'($urandom_range(0, 3));
                w.pattern_end    = (k == plen - 1) || ($urandom_range(0, 29) == 0);
                w.distance_limit = 4'($urandom_range(0, 15));
                w.stack_level    = 6'($urandom_range(0, 63));
                send_word(w, 1'b0, '0, ans);
                if ($urandom_range(0, 11) == 0) begin
                    w.action      = ACT_WALK;
                    w.symbol      = 8'($urandom_range(0, 255));
                    w.stack_level = 6'($urandom_range(0, 63));
                    send_word(w, 1'b0, '0, ans);
                end
            end
            depth = 0;
            nwalk = $urandom_range(6, 24);
            for (int k = 0; k < nwalk; k++) begin
                w.action         = ACT_WALK;
                w.pattern_end    = 1'($urandom_range(0, 1));
                w.distance_limit = 4'($urandom_range(0, 15));
                if ($urandom_range(0, 4) == 0)
                    w.symbol = 8'($urandom_range(0, 255));
                else
                    w.symbol = base + 8'($urandom_range(0, 3));
                if ($urandom_range(0, 19) == 0)
                    w.stack_level = 6'($urandom_range(0, 63));
                else
                    w.stack_level = 6'(depth);
                send_word(w, 1'b0, '0, ans);
                if (!ans.any_active || depth >= 61 || $urandom_range(0, 3) == 0)
                    depth = $urandom_range(0, depth);
                else
                    depth++;
            end
            pat_no++;
        end
        in_ch.valid <= 1'b0;

        while (pending_answers.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (err_cnt == 0) begin
            $display("ALL CHECKS PASSED");
        end else begin
            $display("CHECKS FAILED");
        end
        $finish;
    end

endmodule
